// ----- rtl/gos_pkg.sv -----
// Shared types and constants of the glyph outline segmenter.
// Used by the channel interfaces and by every gos_* module; depends on nothing.
`default_nettype none

package gos_pkg;

  localparam int CoordW    = 16;
  localparam int PosW      = 32;
  localparam int OrigW     = 24;
  localparam int DeltaW    = 16;
  localparam int ScaleW    = 24;
  localparam int ColorW    = 32;
  localparam int ProdW     = PosW + ScaleW;
  localparam int FracW     = 16;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;
  localparam int FifoCntW  = 3;
  localparam int ApbAw     = 3;
  localparam int ApbDw     = 32;

  localparam logic [ScaleW-1:0] ScaleReset = 24'h01_0000;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_SCALE = 1'b0,
    REG_COLOR = 1'b1
  } gos_reg_e;

  typedef enum logic {
    SEG_LINE = 1'b0,
    SEG_QUAD = 1'b1
  } gos_kind_e;

  typedef struct packed {
    logic                     glyph_start;
    logic signed [OrigW-1:0]  origin_x;
    logic signed [OrigW-1:0]  origin_y;
    logic signed [DeltaW-1:0] delta_x;
    logic signed [DeltaW-1:0] delta_y;
    logic                     on_curve;
    logic                     contour_end;
  } gos_in_t;

  typedef struct packed {
    gos_kind_e                seg_kind;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] ctrl_x;
    logic signed [CoordW-1:0] ctrl_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic [ColorW-1:0]        seg_color;
    logic                     last;
  } gos_seg_t;

  typedef struct packed {
    logic [ScaleW-1:0] scale_q16;
    logic [ColorW-1:0] draw_color;
  } gos_cfg_t;

  // product stage toward the segment logic
  typedef struct packed {
    logic             valid;
    logic             glyph_start;
    logic             on_curve;
    logic             contour_end;
    logic             neg_x;
    logic             neg_y;
    logic [ProdW-1:0] prod_x;
    logic [ProdW-1:0] prod_y;
  } gos_prod_t;

  // zero, one or two segment records toward the output queue
  typedef struct packed {
    logic     vld0;
    logic     vld1;
    gos_seg_t seg0;
    gos_seg_t seg1;
  } gos_push_t;

endpackage

`default_nettype wire

// ----- rtl/gos_in_if.sv -----
// Input point channel: valid/ready handshake carrying one gos_in_t beat.
// Depends on gos_pkg.
`default_nettype none

interface gos_in_if;
  import gos_pkg::*;

  logic    valid;
  logic    ready;
  gos_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/gos_out_if.sv -----
// Segment command channel: valid/ready handshake carrying one gos_seg_t beat.
// Depends on gos_pkg.
`default_nettype none

interface gos_out_if;
  import gos_pkg::*;

  logic     valid;
  logic     ready;
  gos_seg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/gos_cfg.sv -----
// APB-style register file holding the scale factor and the draw color.
// Depends on gos_pkg.
`default_nettype none

module gos_cfg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel_i,
  input  wire logic                  penable_i,
  input  wire logic                  pwrite_i,
  input  wire logic [gos_pkg::ApbAw-1:0] paddr_i,
  input  wire logic [gos_pkg::ApbDw-1:0] pwdata_i,
  output logic [gos_pkg::ApbDw-1:0]      prdata_o,
  output logic                       pready_o,
  output gos_pkg::gos_cfg_t          cfg_o
);
  import gos_pkg::*;

  logic [ScaleW-1:0] scale_q;
  logic [ColorW-1:0] color_q;
  logic              wr_en;
  gos_reg_e          reg_sel;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign reg_sel  = gos_reg_e'(paddr_i[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      color_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SCALE: scale_q <= pwdata_i[ScaleW-1:0];
        REG_COLOR: color_q <= pwdata_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCALE: prdata_o = ApbDw'(scale_q);
      REG_COLOR: prdata_o = ApbDw'(color_q);
      default:   prdata_o = '0;
    endcase
  end

  assign cfg_o.scale_q16  = scale_q;
  assign cfg_o.draw_color = color_q;

endmodule

`default_nettype wire

// ----- rtl/gos_scale.sv -----
// Front stages: position accumulator at the input beat, then magnitude times scale.
// Depends on gos_pkg and gos_in_if.
`default_nettype none

module gos_scale (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  gos_in_if.sink                         in_i,
  input  wire logic                      adv_i,
  input  wire logic [gos_pkg::ScaleW-1:0] scale_i,
  output gos_pkg::gos_prod_t             prod_o
);
  import gos_pkg::*;

  logic [PosW-1:0] pos_x_q, pos_x_d;
  logic [PosW-1:0] pos_y_q, pos_y_d;
  logic [PosW-1:0] base_x, base_y;
  logic            accept;

  logic            s1_vld_q;
  logic [PosW-1:0] s1_x_q, s1_y_q;
  logic            s1_gs_q, s1_on_q, s1_ce_q;

  logic            neg_x, neg_y;
  logic [PosW-1:0] mag_x, mag_y;
  gos_prod_t       s2_q;

  assign in_i.ready = adv_i;
  assign accept     = in_i.valid & adv_i;

  // a new glyph restarts the running sum from its origin
  assign base_x = in_i.data.glyph_start
                ? {{(PosW-OrigW){in_i.data.origin_x[OrigW-1]}}, in_i.data.origin_x}
                : pos_x_q;
  assign base_y = in_i.data.glyph_start
                ? {{(PosW-OrigW){in_i.data.origin_y[OrigW-1]}}, in_i.data.origin_y}
                : pos_y_q;
  assign pos_x_d = base_x + {{(PosW-DeltaW){in_i.data.delta_x[DeltaW-1]}}, in_i.data.delta_x};
  assign pos_y_d = base_y + {{(PosW-DeltaW){in_i.data.delta_y[DeltaW-1]}}, in_i.data.delta_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      s1_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= in_i.valid;
      if (accept) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q  <= pos_x_d;
      s1_y_q  <= pos_y_d;
      s1_gs_q <= in_i.data.glyph_start;
      s1_on_q <= in_i.data.on_curve;
      s1_ce_q <= in_i.data.contour_end;
    end
  end

  // sign and magnitude; the most negative value maps to 2^31 unsigned
  assign neg_x = s1_x_q[PosW-1];
  assign neg_y = s1_y_q[PosW-1];
  assign mag_x = neg_x ? (~s1_x_q + PosW'(1)) : s1_x_q;
  assign mag_y = neg_y ? (~s1_y_q + PosW'(1)) : s1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (adv_i) begin
      s2_q.valid <= s1_vld_q;
      if (s1_vld_q) begin
        s2_q.glyph_start <= s1_gs_q;
        s2_q.on_curve    <= s1_on_q;
        s2_q.contour_end <= s1_ce_q;
        s2_q.neg_x       <= neg_x;
        s2_q.neg_y       <= neg_y;
        s2_q.prod_x      <= ProdW'(mag_x) * ProdW'(scale_i);
        s2_q.prod_y      <= ProdW'(mag_y) * ProdW'(scale_i);
      end
    end
  end

  assign prod_o = s2_q;

endmodule

`default_nettype wire

// ----- rtl/gos_seg.sv -----
// Segment stage: saturate pixel coordinates, track contour and curve state,
// build up to two segment records per point. Depends on gos_pkg.
`default_nettype none

module gos_seg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  gos_pkg::gos_prod_t             prod_i,
  input  wire logic [gos_pkg::ColorW-1:0] color_i,
  output gos_pkg::gos_push_t             push_o
);
  import gos_pkg::*;

  localparam int QW = ProdW - FracW;

  function automatic logic signed [CoordW-1:0] to_px(input logic [ProdW-1:0] prod,
                                                    input logic             neg);
    logic [QW-1:0] q;
    logic [QW-1:0] lim;
    q   = prod[ProdW-1:FracW];
    lim = QW'(1) << (CoordW - 1);
    if (neg) begin
      to_px = (q > lim) ? {1'b1, {(CoordW-1){1'b0}}} : -q[CoordW-1:0];
    end else begin
      to_px = (q >= lim) ? {1'b0, {(CoordW-1){1'b1}}} : q[CoordW-1:0];
    end
  endfunction

  // halve the sum, rounding toward zero
  function automatic logic signed [CoordW-1:0] mid(input logic signed [CoordW-1:0] a,
                                                  input logic signed [CoordW-1:0] b);
    logic [CoordW:0] sum;
    logic [CoordW:0] adj;
    sum = {a[CoordW-1], a} + {b[CoordW-1], b};
    adj = sum + {{CoordW{1'b0}}, sum[CoordW]};
    mid = adj[CoordW:1];
  endfunction

  function automatic gos_seg_t mk_seg(input gos_kind_e kind,
                                      input logic signed [CoordW-1:0] sx,
                                      input logic signed [CoordW-1:0] sy,
                                      input logic signed [CoordW-1:0] cx,
                                      input logic signed [CoordW-1:0] cy,
                                      input logic signed [CoordW-1:0] ex,
                                      input logic signed [CoordW-1:0] ey,
                                      input logic [ColorW-1:0]        color,
                                      input logic                     last);
    gos_seg_t s;
    s.seg_kind  = kind;
    s.start_x   = sx;
    s.start_y   = sy;
    s.ctrl_x    = cx;
    s.ctrl_y    = cy;
    s.end_x     = ex;
    s.end_y     = ey;
    s.seg_color = color;
    s.last      = last;
    mk_seg = s;
  endfunction

  logic signed [CoordW-1:0] prev_x_q, prev_y_q;
  logic signed [CoordW-1:0] cs_x_q, cs_y_q, cs_x_d, cs_y_d;
  logic signed [CoordW-1:0] cv_x_q, cv_y_q, cv_x_d, cv_y_d;
  logic signed [CoordW-1:0] ct_x_q, ct_y_q, ct_x_d, ct_y_d;
  logic                     pend_q, pend_d;
  logic                     first_q, first_d;

  logic signed [CoordW-1:0] ex, ey, mx, my;
  logic                     fire, first, pend, ce;
  logic                     pri_vld, cls_vld;
  gos_seg_t                 pri_seg, cls_seg;

  assign fire  = adv_i & prod_i.valid;
  assign ex    = to_px(prod_i.prod_x, prod_i.neg_x);
  assign ey    = to_px(prod_i.prod_y, prod_i.neg_y);
  assign mx    = mid(ct_x_q, ex);
  assign my    = mid(ct_y_q, ey);
  assign ce    = prod_i.contour_end;
  // a new glyph also opens a new contour
  assign first = prod_i.glyph_start | first_q;
  assign pend  = ~prod_i.glyph_start & pend_q;

  always_comb begin
    cs_x_d  = cs_x_q;
    cs_y_d  = cs_y_q;
    cv_x_d  = cv_x_q;
    cv_y_d  = cv_y_q;
    ct_x_d  = ct_x_q;
    ct_y_d  = ct_y_q;
    pend_d  = pend;
    pri_vld = 1'b0;
    cls_vld = 1'b0;
    pri_seg = mk_seg(SEG_LINE, prev_x_q, prev_y_q, '0, '0, ex, ey, color_i, 1'b0);
    cls_seg = mk_seg(SEG_LINE, ex, ey, '0, '0, cs_x_q, cs_y_q, color_i, 1'b0);

    if (first) begin
      cs_x_d = ex;
      cs_y_d = ey;
    end else if (prod_i.on_curve) begin
      pri_vld = 1'b1;
      if (pend) begin
        pri_seg = mk_seg(SEG_QUAD, cv_x_q, cv_y_q, ct_x_q, ct_y_q, ex, ey, color_i, 1'b0);
      end
      cls_vld = ce;
      pend_d  = 1'b0;
    end else begin
      if (pend) begin
        pri_vld = 1'b1;
        pri_seg = mk_seg(SEG_QUAD, cv_x_q, cv_y_q, ct_x_q, ct_y_q, mx, my, color_i, 1'b0);
        cv_x_d  = mx;
        cv_y_d  = my;
      end else begin
        cv_x_d = prev_x_q;
        cv_y_d = prev_y_q;
      end
      pend_d  = 1'b1;
      ct_x_d  = ex;
      ct_y_d  = ey;
      cls_vld = ce;
      cls_seg = mk_seg(SEG_QUAD, cv_x_d, cv_y_d, ex, ey, cs_x_q, cs_y_q, color_i, 1'b0);
    end

    first_d = 1'b0;
    if (ce) begin
      first_d = 1'b1;
      pend_d  = 1'b0;
    end
  end

  // pack: the primary segment goes first, the closing one after it
  always_comb begin
    push_o.vld0 = fire & (pri_vld | cls_vld);
    push_o.vld1 = fire & pri_vld & cls_vld;
    push_o.seg0 = pri_vld ? pri_seg : cls_seg;
    push_o.seg1 = cls_seg;
    push_o.seg0.last = ~(pri_vld & cls_vld);
    push_o.seg1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      cs_x_q   <= '0;
      cs_y_q   <= '0;
      cv_x_q   <= '0;
      cv_y_q   <= '0;
      ct_x_q   <= '0;
      ct_y_q   <= '0;
      pend_q   <= 1'b0;
      first_q  <= 1'b1;
    end else if (fire) begin
      prev_x_q <= ex;
      prev_y_q <= ey;
      cs_x_q   <= cs_x_d;
      cs_y_q   <= cs_y_d;
      cv_x_q   <= cv_x_d;
      cv_y_q   <= cv_y_d;
      ct_x_q   <= ct_x_d;
      ct_y_q   <= ct_y_d;
      pend_q   <= pend_d;
      first_q  <= first_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gos_fifo.sv -----
// Output queue: takes up to two segment records a cycle, hands out one beat a cycle while out_o is ready.
// Depends on gos_pkg and gos_out_if.
`default_nettype none

module gos_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  gos_pkg::gos_push_t push_i,
  output logic               space_o,
  gos_out_if.source          out_o
);
  import gos_pkg::*;

  gos_seg_t              mem_q [FifoDepth];
  logic [FifoAw-1:0]     wptr_q, rptr_q;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic [FifoCntW-1:0]   push_n;
  logic                  pop;

  assign push_n = FifoCntW'(push_i.vld0) + FifoCntW'(push_i.vld1);
  assign pop    = out_o.valid & out_o.ready;
  assign cnt_d  = cnt_q + push_n - FifoCntW'(pop);

  // room for a full pair of records before the pipeline may advance
  assign space_o = (cnt_q <= FifoCntW'(FifoDepth - 2));

  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + push_n[FifoAw-1:0];
      rptr_q <= rptr_q + FifoAw'(pop);
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wptr_q] <= push_i.seg0;
    end
    if (push_i.vld1) begin
      mem_q[wptr_q + FifoAw'(1)] <= push_i.seg1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/glyph_outline_segmenter.sv -----
// Glyph outline segmenter: points in on in_i, line and quadratic segment beats out
// on out_o, registers on the APB-style port. Uses gos_pkg, gos_in_if, gos_out_if,
// gos_cfg, gos_scale, gos_seg and gos_fifo.
//
// Each in_i beat is one outline point; it yields zero, one or two out_o beats,
// the final one of a point flagged with last. scale_q16 lives at byte 0x0 and
// draw_color at 0x4; write them only while the block is idle.
// A point enters the accumulator register at the edge that takes its in_i beat,
// then the product register, then the segment build writes it into the queue,
// from which out_o offers its first segment.
// Throughput: one point per cycle while the output keeps up; the sustained rate
// is bounded by out_o at one segment beat per cycle, so points that each make
// two segments fill the queue and stall in_i.
// A four-entry output queue decouples the sides; in_i.ready drops when fewer
// than two entries are free, which stalls the whole three-stage pipeline in
// place. Nothing is lost or repeated under any stall pattern.
// Reset clears the running position, the contour state (the next point opens a
// contour), empties the queue, and returns scale_q16 to 1.0 and draw_color to 0.
`default_nettype none

module glyph_outline_segmenter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gos_pkg::ApbAw-1:0]    paddr,
  input  wire logic [gos_pkg::ApbDw-1:0]    pwdata,
  output logic [gos_pkg::ApbDw-1:0]         prdata,
  output logic                              pready,
  gos_in_if.sink                            in_i,
  gos_out_if.source                         out_o
);
  import gos_pkg::*;

  gos_cfg_t  cfg;
  gos_prod_t prod;
  gos_push_t push;
  logic      adv;

  gos_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  gos_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .scale_i (cfg.scale_q16),
    .prod_o  (prod)
  );

  gos_seg u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .prod_i  (prod),
    .color_i (cfg.draw_color),
    .push_o  (push)
  );

  gos_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (adv),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
